// ----- design/jsbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsbd_pkg
// Shared types and codes for the JSON string body decoder.
// ----------------------------------------------------------------------------
package jsbd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned HEX_ACC_W = 16;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_CHAR     = 3'd0;
    localparam status_t ST_END      = 3'd1;
    localparam status_t ST_BAD_ESC  = 3'd2;
    localparam status_t ST_BAD_UTF8 = 3'd3;
    localparam status_t ST_UNTERM   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2,
        PH_CONT = 2'd3
    } phase_t;

    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_B         = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F         = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R         = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T         = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;

endpackage

// ----- design/json_string_body_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_body_decoder
// Decodes a JSON string body, one byte per transfer, into code points.
// ----------------------------------------------------------------------------
// Takes one byte per cycle after the opening quote and returns at most one
// result per byte: a decoded code point, the end of the string, or an error
// (illegal escape, illegal UTF-8, unterminated). Each byte is decoded in the
// cycle it is accepted, against the phase, accumulator and remaining-byte
// count, and the result lands in a single output register. The input side
// stays ready whenever that register is empty or is being drained, so the
// sustained rate is one byte per cycle, with the result registered at the
// transfer. After an end or an error the decoder is idle for the next string.
module json_string_body_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jsbd_pkg::BYTE_W-1:0]     byte_in,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jsbd_pkg::CP_W-1:0]       code_point,
    output logic [jsbd_pkg::STATUS_W-1:0]   status
);
    import jsbd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [CP_W-1:0]     acc_reg, acc_next;
    logic [1:0]          rem_reg, rem_next;
    logic                out_valid_reg;
    logic [CP_W-1:0]     code_point_reg;
    status_t             status_reg;

    logic                emit;
    logic [CP_W-1:0]     emit_cp;
    status_t             emit_st;
    logic                hex_ok;
    logic [3:0]          hex_val;
    logic [HEX_ACC_W-1:0] hex_acc;
    logic [CP_W-1:0]     cont_acc;
    logic                in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (byte_in >= 8'h30 && byte_in <= 8'h39)
        begin
            hex_val = byte_in[3:0];
        end
        else if ((byte_in >= 8'h61 && byte_in <= 8'h66) ||
                 (byte_in >= 8'h41 && byte_in <= 8'h46))
        begin
            hex_val = byte_in[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc  = {acc_reg[HEX_ACC_W-5:0], hex_val};
    assign cont_acc = {acc_reg[CP_W-7:0], byte_in[5:0]};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        emit_cp    = '0;
        emit_st    = ST_CHAR;

        unique case (phase_reg)
            PH_ESC:
            begin
                emit = 1'b1;
                unique case (byte_in)
                    CH_B:    emit_cp = CP_W'(8'h08);
                    CH_F:    emit_cp = CP_W'(8'h0C);
                    CH_N:    emit_cp = CP_W'(8'h0A);
                    CH_R:    emit_cp = CP_W'(8'h0D);
                    CH_T:    emit_cp = CP_W'(8'h09);
                    CH_U:    emit_cp = '0;
                    default: emit_cp = CP_W'(byte_in);
                endcase
                if (byte_in == CH_U)
                begin
                    if (last_byte)
                    begin
                        emit_st = ST_BAD_ESC;
                    end
                    else
                    begin
                        emit       = 1'b0;
                        phase_next = PH_HEX;
                        acc_next   = '0;
                        rem_next   = 2'd3;
                    end
                end
                else if (last_byte)
                begin
                    emit_st = ST_UNTERM;
                end
            end
            PH_HEX:
            begin
                if (!hex_ok)
                begin
                    emit    = 1'b1;
                    emit_st = ST_BAD_ESC;
                end
                else if (rem_reg == 2'd0)
                begin
                    emit    = 1'b1;
                    emit_cp = CP_W'(hex_acc);
                    emit_st = last_byte ? ST_UNTERM : ST_CHAR;
                end
                else if (last_byte)
                begin
                    emit    = 1'b1;
                    emit_st = ST_BAD_ESC;
                end
                else
                begin
                    acc_next = CP_W'(hex_acc);
                    rem_next = rem_reg - 2'd1;
                end
            end
            PH_CONT:
            begin
                if (byte_in[7:6] != 2'b10)
                begin
                    emit    = 1'b1;
                    emit_st = ST_BAD_UTF8;
                end
                else if (rem_reg == 2'd0)
                begin
                    emit    = 1'b1;
                    emit_cp = cont_acc;
                    emit_st = last_byte ? ST_UNTERM : ST_CHAR;
                end
                else if (last_byte)
                begin
                    emit    = 1'b1;
                    emit_st = ST_BAD_UTF8;
                end
                else
                begin
                    acc_next = cont_acc;
                    rem_next = rem_reg - 2'd1;
                end
            end
            default:
            begin
                if (byte_in == CH_QUOTE)
                begin
                    emit    = 1'b1;
                    emit_st = last_byte ? ST_UNTERM : ST_END;
                end
                else if (byte_in == CH_BACKSLASH)
                begin
                    if (last_byte)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_ESC;
                    end
                    else
                    begin
                        phase_next = PH_ESC;
                    end
                end
                else if (!byte_in[7])
                begin
                    emit    = 1'b1;
                    emit_cp = CP_W'(byte_in);
                    emit_st = last_byte ? ST_UNTERM : ST_CHAR;
                end
                else if (byte_in >= 8'hF8 || last_byte)
                begin
                    emit    = 1'b1;
                    emit_st = ST_BAD_UTF8;
                end
                else
                begin
                    phase_next = PH_CONT;
                    if (byte_in < 8'hE0)
                    begin
                        acc_next = CP_W'(byte_in[4:0]);
                        rem_next = 2'd0;
                    end
                    else if (byte_in < 8'hF0)
                    begin
                        acc_next = CP_W'(byte_in[3:0]);
                        rem_next = 2'd1;
                    end
                    else
                    begin
                        acc_next = CP_W'(byte_in[2:0]);
                        rem_next = 2'd2;
                    end
                end
            end
        endcase

        if (emit)
        begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            rem_next   = 2'd0;
            if (emit_st != ST_CHAR)
            begin
                emit_cp = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            rem_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
            end
            if (in_xfer)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            code_point_reg <= emit_cp;
            status_reg     <= emit_st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign status     = status_reg;

endmodule
